/* src/mixed_breit_wigner_amplitude_unit_defines.svh */
// assertion macros used by the checker file
`ifndef MIXED_BREIT_WIGNER_AMPLITUDE_UNIT_DEFINES_SVH
`define MIXED_BREIT_WIGNER_AMPLITUDE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MBW_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbw check failed");

// next-cycle implication, disabled while in reset
`define MBW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbw check failed");

`endif

/* src/mbw_pkg.sv */
// types, widths, constants and cordic helpers of the breit-wigner amplitude unit
`default_nettype none
package mbw_pkg;

    // field widths
    localparam int XW    = 18;
    localparam int MASSW = 18;
    localparam int WIDW  = 17;
    localparam int MIXW  = 20;
    localparam int CFGDW = 20;
    localparam int CFGIW = 3;
    localparam int INTW  = 32;
    localparam int PHW   = 16;

    // register indexes
    localparam logic [CFGIW-1:0] REG_MASS_ONE    = 3'd0;
    localparam logic [CFGIW-1:0] REG_WIDTH_ONE   = 3'd1;
    localparam logic [CFGIW-1:0] REG_MASS_TWO    = 3'd2;
    localparam logic [CFGIW-1:0] REG_WIDTH_TWO   = 3'd3;
    localparam logic [CFGIW-1:0] REG_MIX_REAL    = 3'd4;
    localparam logic [CFGIW-1:0] REG_MIX_IMAG    = 3'd5;
    localparam logic [CFGIW-1:0] REG_DOUBLE_MODE = 3'd6;

    localparam logic [MASSW-1:0] MASS_RESET  = 18'd98304;
    localparam logic [WIDW-1:0]  WIDTH_RESET = 17'd19661;

    // datapath widths
    localparam int FRAC   = 16;
    localparam int SW     = 2 * XW;            // x squared
    localparam int GMW    = WIDW + MASSW;      // width times mass
    localparam int RW     = SW + 1 - FRAC;     // real part of a bw term
    localparam int IW     = GMW - FRAC + 1;    // imaginary part of a bw term
    localparam int PW     = 44;                // components of N
    localparam int HW     = PW / 2;            // half split for the squares
    localparam int TW     = 24;                // components of T
    localparam int TSQW   = 46;                // |T|^2
    localparam int NUM_SHIFT = 46;
    localparam int NUMW   = TSQW + NUM_SHIFT;
    localparam int DENW   = 2 * PW;
    localparam int QW     = INTW;
    localparam int QBW    = 5;
    localparam int CMPW   = DENW + QW;
    localparam int CW     = 47;                // cordic x and y
    localparam int ZW     = 32;                // cordic angle
    localparam int CORDIC_STEPS = 20;
    localparam int FRONT_STAGES = 6;
    localparam int PH_SHIFT = 13;

    localparam logic signed [ZW-1:0] PI_UNITS   = 32'sd268435456;
    localparam logic signed [ZW-1:0] ROUND_BIAS = 32'sd4096;

    typedef struct packed {
        logic [MASSW-1:0]        mass_one;
        logic [WIDW-1:0]         width_one;
        logic [MASSW-1:0]        mass_two;
        logic [WIDW-1:0]         width_two;
        logic signed [MIXW-1:0]  mix_real;
        logic signed [MIXW-1:0]  mix_imag;
        logic                    double_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [DENW-1:0] den;
        logic [QW-1:0]   quo;
        logic            ovf;
        logic            nzero;
        logic            tzero;
        cordic_t         ct;
        cordic_t         cn;
    } pipe_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [QBW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 32'sd67108864;
            5'd1:    v = 32'sd39616676;
            5'd2:    v = 32'sd20932363;
            5'd3:    v = 32'sd10625594;
            5'd4:    v = 32'sd5333416;
            5'd5:    v = 32'sd2669308;
            5'd6:    v = 32'sd1334980;
            5'd7:    v = 32'sd667531;
            5'd8:    v = 32'sd333770;
            5'd9:    v = 32'sd166886;
            5'd10:   v = 32'sd83443;
            5'd11:   v = 32'sd41722;
            5'd12:   v = 32'sd20861;
            5'd13:   v = 32'sd10430;
            5'd14:   v = 32'sd5215;
            5'd15:   v = 32'sd2608;
            5'd16:   v = 32'sd1304;
            5'd17:   v = 32'sd652;
            5'd18:   v = 32'sd326;
            5'd19:   v = 32'sd163;
            default: v = '0;
        endcase
        return v;
    endfunction

    // rotate a left half-plane vector by pi before the micro-rotations
    function automatic cordic_t cordic_fold(input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y);
        cordic_t r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x[CW-1])
        begin
            r.z = y[CW-1] ? -PI_UNITS : PI_UNITS;
            r.x = -x;
            r.y = -y;
        end
        return r;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t a, input logic [QBW-1:0] i);
        cordic_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        r  = a;
        if (!a.y[CW-1] && (a.y != '0))
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_entry(i);
        end
        else
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_entry(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/mbw_front.sv */
// front pipeline: bw terms, denominator N, numerator T, squared magnitudes, cordic fold
`default_nettype none
module mbw_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [mbw_pkg::XW-1:0] mass_sample,
    input  wire mbw_pkg::cfg_t        cfg,
    output logic                      out_vld,
    output mbw_pkg::pipe_t            out_data
);
    import mbw_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    // stage 1: raw products
    logic [SW-1:0]  xsq_reg, m1sq_reg, m2sq_reg;
    logic [GMW-1:0] gm1_reg, gm2_reg;

    // stage 2: bw terms
    logic signed [SW:0]   diff1, diff2;
    logic signed [RW-1:0] r1_reg, r2_reg;
    logic signed [IW-1:0] i1_reg, i2_reg;

    // stage 3: cross products and numerator
    logic signed [2*RW-1:0]  rr_next, rr_reg;
    logic signed [2*IW-1:0]  ii_next, ii_reg;
    logic signed [RW+IW-1:0] ri_next, ri_reg, ir_next, ir_reg;
    logic signed [TW-1:0]    tre_next, tre_reg, tim_next, tim_reg;

    // stage 4: denominator
    logic signed [PW-1:0] nre_next, nre_reg, nim_next, nim_reg;
    logic signed [TW-1:0] tre4_reg, tim4_reg;

    // stage 5: split squares and fold
    logic [PW-1:0]     nre_m, nim_m;
    logic [TW-1:0]     tre_m, tim_m;
    logic [2*TW:0]     tsum;
    logic [PW-1:0]     rhh_reg, rhl_reg, rll_reg, ihh_reg, ihl_reg, ill_reg;
    logic [TSQW-1:0]   tsq_reg;
    logic              nzero_reg, tzero_reg;
    cordic_t           ct_reg, cn_reg;

    pipe_t out_next, out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
    end

    assign diff1 = $signed({1'b0, m1sq_reg}) - $signed({1'b0, xsq_reg});
    assign diff2 = $signed({1'b0, m2sq_reg}) - $signed({1'b0, xsq_reg});

    assign rr_next = r1_reg * r2_reg;
    assign ii_next = i1_reg * i2_reg;
    assign ri_next = r1_reg * i2_reg;
    assign ir_next = i1_reg * r2_reg;
    assign tre_next = (TW'(r2_reg) <<< 1) + (cfg.double_mode ? TW'(r1_reg) : {TW{1'b0}});
    assign tim_next = (TW'(i2_reg) <<< 1) + (cfg.double_mode ? TW'(i1_reg) : {TW{1'b0}});

    assign nre_next = PW'(rr_reg) - PW'(ii_reg) - (PW'($signed(cfg.mix_real)) <<< FRAC);
    assign nim_next = PW'(ri_reg) + PW'(ir_reg) - (PW'($signed(cfg.mix_imag)) <<< FRAC);

    assign nre_m = nre_reg[PW-1] ? PW'(-nre_reg) : PW'(nre_reg);
    assign nim_m = nim_reg[PW-1] ? PW'(-nim_reg) : PW'(nim_reg);
    assign tre_m = tre4_reg[TW-1] ? TW'(-tre4_reg) : TW'(tre4_reg);
    assign tim_m = tim4_reg[TW-1] ? TW'(-tim4_reg) : TW'(tim4_reg);
    assign tsum  = tre_m * tre_m + tim_m * tim_m;

    // a^2 = hh * 2^(2*HW) + hl * 2^(HW+1) + ll
    always_comb
    begin
        out_next       = '0;
        out_next.rem   = {tsq_reg, {NUM_SHIFT{1'b0}}};
        out_next.den   = {rhh_reg, {2*HW{1'b0}}} + DENW'({rhl_reg, {HW+1{1'b0}}})
                       + DENW'(rll_reg)
                       + {ihh_reg, {2*HW{1'b0}}} + DENW'({ihl_reg, {HW+1{1'b0}}})
                       + DENW'(ill_reg);
        out_next.nzero = nzero_reg;
        out_next.tzero = tzero_reg;
        out_next.ct    = ct_reg;
        out_next.cn    = cn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xsq_reg  <= mass_sample * mass_sample;
            m1sq_reg <= cfg.mass_one * cfg.mass_one;
            m2sq_reg <= cfg.mass_two * cfg.mass_two;
            gm1_reg  <= cfg.width_one * cfg.mass_one;
            gm2_reg  <= cfg.width_two * cfg.mass_two;

            r1_reg <= diff1[SW:FRAC];
            r2_reg <= diff2[SW:FRAC];
            i1_reg <= -$signed({1'b0, gm1_reg[GMW-1:FRAC]});
            i2_reg <= -$signed({1'b0, gm2_reg[GMW-1:FRAC]});

            rr_reg  <= rr_next;
            ii_reg  <= ii_next;
            ri_reg  <= ri_next;
            ir_reg  <= ir_next;
            tre_reg <= tre_next;
            tim_reg <= tim_next;

            nre_reg  <= nre_next;
            nim_reg  <= nim_next;
            tre4_reg <= tre_reg;
            tim4_reg <= tim_reg;

            rhh_reg   <= nre_m[PW-1:HW] * nre_m[PW-1:HW];
            rhl_reg   <= nre_m[PW-1:HW] * nre_m[HW-1:0];
            rll_reg   <= nre_m[HW-1:0] * nre_m[HW-1:0];
            ihh_reg   <= nim_m[PW-1:HW] * nim_m[PW-1:HW];
            ihl_reg   <= nim_m[PW-1:HW] * nim_m[HW-1:0];
            ill_reg   <= nim_m[HW-1:0] * nim_m[HW-1:0];
            tsq_reg   <= tsum[TSQW-1:0];
            nzero_reg <= (nre_reg == '0) && (nim_reg == '0);
            tzero_reg <= (tre4_reg == '0) && (tim4_reg == '0);
            ct_reg    <= cordic_fold(CW'(tre4_reg), CW'(tim4_reg));
            cn_reg    <= cordic_fold(CW'(nre_reg), CW'(nim_reg));

            out_reg <= out_next;
        end
    end

    assign out_vld  = vld_reg[FRONT_STAGES-1];
    assign out_data = out_reg;

endmodule
`default_nettype wire

/* src/mbw_step.sv */
// one stage: one restoring divide bit; a cordic rotation of both vectors for index < 20
`default_nettype none
module mbw_step (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic [mbw_pkg::QBW-1:0] step_index,
    input  wire logic                    in_vld,
    input  wire mbw_pkg::pipe_t          in_data,
    output logic                         out_vld,
    output mbw_pkg::pipe_t               out_data
);
    import mbw_pkg::*;

    logic [QBW-1:0]  bit_pos;
    logic [CMPW-1:0] dsh;
    logic            take;
    pipe_t           data_next, data_reg;
    logic            vld_reg;

    assign bit_pos = QBW'(QW - 1) - step_index;
    assign dsh     = CMPW'(in_data.den) << bit_pos;
    assign take    = CMPW'(in_data.rem) >= dsh;

    always_comb
    begin
        data_next     = in_data;
        data_next.quo = {in_data.quo[QW-2:0], take};
        if (take)
            data_next.rem = in_data.rem - dsh[NUMW-1:0];
        if (step_index < QBW'(CORDIC_STEPS))
        begin
            data_next.ct = cordic_step(in_data.ct, step_index);
            data_next.cn = cordic_step(in_data.cn, step_index);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

/* src/mixed_breit_wigner_amplitude_unit.sv */
// a sample passes the front stages, the overflow register, the divide steps and the output register
// throughput: one item per cycle unless stalled; the 32-bit restoring divide, one bit per stage, sets depth
// the whole pipeline advances together and holds when a result waits on out_ready
// reset clears all valid bits and loads the register reset values; no clearing pass
`default_nettype none
module mixed_breit_wigner_amplitude_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [mbw_pkg::CFGIW-1:0]   cfg_index,
    input  wire logic [mbw_pkg::CFGDW-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mbw_pkg::XW-1:0]      mass_sample,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mbw_pkg::INTW-1:0]         intensity,
    output logic signed [mbw_pkg::PHW-1:0]   phase,
    output logic                             saturated
);
    import mbw_pkg::*;

    cfg_t  cfg_reg;
    logic  adv;

    logic  front_vld;
    pipe_t front_data;

    logic  ovf_vld_reg;
    pipe_t ovf_next, ovf_reg;

    logic  step_vld [QW+1];
    pipe_t step_data [QW+1];

    logic                  out_valid_reg;
    logic [INTW-1:0]       intensity_reg;
    logic signed [PHW-1:0] phase_reg;
    logic                  saturated_reg;
    logic signed [ZW-1:0]  ang_diff;
    pipe_t                 last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mass_one    <= MASS_RESET;
            cfg_reg.width_one   <= WIDTH_RESET;
            cfg_reg.mass_two    <= MASS_RESET;
            cfg_reg.width_two   <= WIDTH_RESET;
            cfg_reg.mix_real    <= '0;
            cfg_reg.mix_imag    <= '0;
            cfg_reg.double_mode <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MASS_ONE:    cfg_reg.mass_one    <= cfg_data[MASSW-1:0];
                REG_WIDTH_ONE:   cfg_reg.width_one   <= cfg_data[WIDW-1:0];
                REG_MASS_TWO:    cfg_reg.mass_two    <= cfg_data[MASSW-1:0];
                REG_WIDTH_TWO:   cfg_reg.width_two   <= cfg_data[WIDW-1:0];
                REG_MIX_REAL:    cfg_reg.mix_real    <= cfg_data[MIXW-1:0];
                REG_MIX_IMAG:    cfg_reg.mix_imag    <= cfg_data[MIXW-1:0];
                REG_DOUBLE_MODE: cfg_reg.double_mode <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    mbw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .mass_sample (mass_sample),
        .cfg         (cfg_reg),
        .out_vld     (front_vld),
        .out_data    (front_data)
    );

    // quotient of 2^32 or more clips
    always_comb
    begin
        ovf_next     = front_data;
        ovf_next.ovf = CMPW'(front_data.rem) >= {front_data.den, {QW{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_vld_reg <= 1'b0;
        else if (adv)
            ovf_vld_reg <= front_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ovf_reg <= ovf_next;
    end

    assign step_vld[0]  = ovf_vld_reg;
    assign step_data[0] = ovf_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        mbw_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .step_index (QBW'(j)),
            .in_vld     (step_vld[j]),
            .in_data    (step_data[j]),
            .out_vld    (step_vld[j+1]),
            .out_data   (step_data[j+1])
        );
    end

    assign last     = step_data[QW];
    assign ang_diff = last.ct.z - last.cn.z + ROUND_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= step_vld[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            intensity_reg <= last.ovf ? {INTW{1'b1}} : last.quo;
            saturated_reg <= last.ovf;
            // zero N or zero T carries no phase
            phase_reg     <= (last.nzero || last.tzero) ? '0 : ang_diff[PH_SHIFT +: PHW];
        end
    end

    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;
    assign phase     = phase_reg;
    assign saturated = saturated_reg;

endmodule
`default_nettype wire

/* src/mbw_checker.sv */
// port-level checks of the amplitude unit, bound to the top level
`default_nettype none
`include "mixed_breit_wigner_amplitude_unit_defines.svh"
module mbw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_write_en,
    input wire logic [2:0]  cfg_index,
    input wire logic [19:0] cfg_data,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [17:0] mass_sample,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] intensity,
    input wire logic [15:0] phase,
    input wire logic        saturated
);

    `MBW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(intensity) && $stable(phase) && $stable(saturated))

    `MBW_ASSERT_SAME(a_sat_clips, clk, rst_n, out_valid && saturated, intensity == 32'hFFFFFFFF)

    `MBW_ASSERT_SAME(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)

    `MBW_ASSERT_SAME(a_empty_takes_in, clk, rst_n, !out_valid, in_ready)

endmodule

bind mixed_breit_wigner_amplitude_unit mbw_checker u_mbw_checker (.*);
`default_nettype wire
